// File: sv/baro_pkg.sv
// Shared types and constants of the barometer compensation pipeline.
// Depends on nothing; used by baro_div and baro_sensor_compensation_top.
package baro_pkg;

    localparam int ADC_W  = 20;
    localparam int CFG_W  = 64;
    localparam int IDX_W  = 3;
    localparam int DIV_W  = 64;

    localparam logic [IDX_W-1:0] REG_TRIM_T  = 3'd0;
    localparam logic [IDX_W-1:0] REG_TRIM_PA = 3'd1;
    localparam logic [IDX_W-1:0] REG_TRIM_PB = 3'd2;
    localparam logic [IDX_W-1:0] REG_TRIM_PC = 3'd3;

    localparam logic [32:0] FINE_OFFSET = 33'd128000;
    localparam logic [20:0] ADC_FULL    = 21'd1048576;
    localparam logic [63:0] P_SCALE     = 64'd3125;
    localparam logic [31:0] T_ROUND     = 32'd128;

    typedef struct packed {
        logic [ADC_W-1:0] adc_temperature;
        logic [ADC_W-1:0] adc_pressure;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic        [31:0] pressure_q24_8;
        logic               pressure_valid;
    } t_out_word;

endpackage

// File: sv/baro_sensor_compensation_top.sv
// Top level of the barometer compensation pipeline: trim registers and datapath.
// Depends on baro_pkg and instantiates the pipelined divider baro_div.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------
//  input   | in        | i_in_valid / o_in_ready   | i_in_word  (t_in_word)
//  output  | out       | o_out_valid / i_out_ready | o_out_word (t_out_word)
//  config  | in        | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// One word is accepted per cycle while no result waits at the output. Each word
// passes 12 stages of trim arithmetic, 66 divider stages (input, one per quotient
// bit, output) and 5 stages of final correction and saturation.
// The synchronous active-low reset clears the valid bits and the trim words.
// When a result waits at the output, the whole pipeline holds in place and
// o_in_ready is low; nothing is dropped or repeated.
module baro_sensor_compensation_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  baro_pkg::t_in_word             i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output baro_pkg::t_out_word            o_out_word,
    input  logic                           i_cfg_we,
    input  logic [baro_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [baro_pkg::CFG_W-1:0]     i_cfg_data
);

    // The divider carries the temperature result and the nonzero-divisor flag.
    localparam int SIDE_W = 33;

    // Trim registers.
    logic [47:0] r_trim_t;
    logic [63:0] r_trim_pa;
    logic [63:0] r_trim_pb;
    logic [15:0] r_trim_pc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trim_t  <= '0;
            r_trim_pa <= '0;
            r_trim_pb <= '0;
            r_trim_pc <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                baro_pkg::REG_TRIM_T:  r_trim_t  <= i_cfg_data[47:0];
                baro_pkg::REG_TRIM_PA: r_trim_pa <= i_cfg_data;
                baro_pkg::REG_TRIM_PB: r_trim_pb <= i_cfg_data;
                baro_pkg::REG_TRIM_PC: r_trim_pc <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Trim fields. The signed ones are sign-extended where they are used.
    logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = r_trim_t[15:0];
    assign t2 = r_trim_t[31:16];
    assign t3 = r_trim_t[47:32];
    assign p1 = r_trim_pa[15:0];
    assign p2 = r_trim_pa[31:16];
    assign p3 = r_trim_pa[47:32];
    assign p4 = r_trim_pa[63:48];
    assign p5 = r_trim_pb[15:0];
    assign p6 = r_trim_pb[31:16];
    assign p7 = r_trim_pb[47:32];
    assign p8 = r_trim_pb[63:48];
    assign p9 = r_trim_pc;

    // Every stage moves together; a waiting result holds the whole pipeline.
    logic r_out_vld;
    logic en;
    assign en         = ~r_out_vld | i_out_ready;
    assign o_in_ready = en;

    // Valid bits of the twelve stages before the divider and four after it.
    logic [11:0] r_vpre;
    logic [3:0]  r_vpost;

    // Pre-divider payload registers.
    logic [19:0] r_at, r_ap, r_ap2, r_ap3, r_ap4, r_ap5, r_ap6, r_ap7, r_ap8, r_ap9, r_ap10;
    logic [31:0] r_d1, r_d2, r_m1, r_sq, r_v1t, r_m3, r_fine;
    logic [31:0] r_tc6, r_tc7, r_tc8, r_tc9, r_tc10, r_tc11;
    logic [32:0] r_x;
    logic [63:0] r_xx, r_xp5, r_xp2, r_xp5b, r_xp2b, r_a, r_b;
    logic [63:0] r_v2, r_v2b, r_v1pre, r_v1m, r_v1, r_pn, r_num, r_den;
    logic        r_nz;

    // Combinational next values of the pre-divider stages.
    logic [31:0] n_d1, n_d2, n_m1, n_sq, n_v1t, n_m3, n_fine, n_tc, f5;
    logic [32:0] n_x;
    logic signed [65:0] xxf;
    logic signed [48:0] xp5f, xp2f;
    logic signed [79:0] af, bf;
    logic [79:0]        v1f;
    logic [63:0] n_v2, n_v1pre, n_v1, n_pn, n_num;

    always_comb begin
        n_d1 = {15'b0, r_at[19:3]} - {15'b0, t1, 1'b0};
        n_d2 = {16'b0, r_at[19:4]} - {16'b0, t1};
        n_m1 = r_d1 * {{16{t2[15]}}, t2};
        n_sq = r_d2 * r_d2;
        n_v1t = 32'($signed(r_m1) >>> 11);
        n_m3 = 32'($signed(r_sq) >>> 12) * {{16{t3[15]}}, t3};
        n_fine = r_v1t + 32'($signed(r_m3) >>> 14);
        // Temperature in hundredths: (fine * 5 + 128) >> 8, wrapping in 32 bits.
        f5 = (r_fine << 2) + r_fine + baro_pkg::T_ROUND;
        n_tc = 32'($signed(f5) >>> 8);
        n_x = {r_fine[31], r_fine} - baro_pkg::FINE_OFFSET;
        xxf  = $signed(r_x) * $signed(r_x);
        xp5f = $signed(r_x) * $signed(p5);
        xp2f = $signed(r_x) * $signed(p2);
        af = $signed(r_xx) * $signed(p6);
        bf = $signed(r_xx) * $signed(p3);
        // The x * P5 and x * P2 products are delayed one stage to line up with xx * P6 and xx * P3.
        n_v2 = r_a + (r_xp5b << 17) + ({{48{p4[15]}}, p4} << 35);
        n_v1pre = 64'($signed(r_b) >>> 8) + (r_xp2b << 12) + (64'd1 << 47);
        v1f = r_v1pre * p1;
        n_v1 = 64'($signed(r_v1m) >>> 33);
        n_pn = ({43'b0, (baro_pkg::ADC_FULL - {1'b0, r_ap10})} << 31) - r_v2b;
        n_num = r_pn * baro_pkg::P_SCALE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vpre <= '0;
        end else if (en) begin
            r_vpre <= {r_vpre[10:0], i_in_valid};
        end
        if (en) begin
            r_at    <= i_in_word.adc_temperature;
            r_ap    <= i_in_word.adc_pressure;
            r_d1    <= n_d1;
            r_d2    <= n_d2;
            r_ap2   <= r_ap;
            r_m1    <= n_m1;
            r_sq    <= n_sq;
            r_ap3   <= r_ap2;
            r_v1t   <= n_v1t;
            r_m3    <= n_m3;
            r_ap4   <= r_ap3;
            r_fine  <= n_fine;
            r_ap5   <= r_ap4;
            r_tc6   <= n_tc;
            r_x     <= n_x;
            r_ap6   <= r_ap5;
            r_xx    <= xxf[63:0];
            r_xp5   <= {{15{xp5f[48]}}, xp5f};
            r_xp2   <= {{15{xp2f[48]}}, xp2f};
            r_tc7   <= r_tc6;
            r_ap7   <= r_ap6;
            r_a     <= af[63:0];
            r_b     <= bf[63:0];
            r_xp5b  <= r_xp5;
            r_xp2b  <= r_xp2;
            r_tc8   <= r_tc7;
            r_ap8   <= r_ap7;
            r_v2    <= n_v2;
            r_v1pre <= n_v1pre;
            r_tc9   <= r_tc8;
            r_ap9   <= r_ap8;
            r_v1m   <= v1f[63:0];
            r_v2b   <= r_v2;
            r_tc10  <= r_tc9;
            r_ap10  <= r_ap9;
            r_v1    <= n_v1;
            r_pn    <= n_pn;
            r_tc11  <= r_tc10;
            r_num   <= n_num;
            r_den   <= r_v1;
            r_nz    <= |r_v1;
        end
    end

    // Divider: quotient of the scaled pressure numerator by v1.
    logic              div_vld;
    logic [63:0]       div_quo;
    logic [SIDE_W-1:0] div_side;
    logic [31:0]       r_tc12;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tc12 <= r_tc11;
        end
    end

    baro_div #(
        .SIDE_W (SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_vpre[11]),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_side  ({r_tc12, r_nz}),
        .o_vld   (div_vld),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    // Post-divider stages: p9 * ps * ps and p8 * p corrections, then saturation.
    logic [63:0] r_pa, r_psa, r_ma, r_p8p, r_pb, r_ll, r_w2, r_s1, r_w1, r_s2;
    logic [31:0] r_hl, r_lh;
    logic [SIDE_W-1:0] r_sda, r_sdb, r_sdc, r_sdd;
    baro_pkg::t_out_word r_out_word;

    logic [63:0]        ps, n_ll, w1p, n_w1, n_s2, pf;
    logic signed [79:0] mf, p8f;
    logic [31:0]        n_hl, n_lh, pres;

    always_comb begin
        ps   = 64'($signed(div_quo) >>> 13);
        mf   = $signed(ps) * $signed(p9);
        p8f  = $signed(div_quo) * $signed(p8);
        n_ll = r_ma[31:0] * r_psa[31:0];
        n_hl = r_ma[63:32] * r_psa[31:0];
        n_lh = r_ma[31:0] * r_psa[63:32];
        w1p  = r_ll + {r_hl + r_lh, 32'b0};
        n_w1 = 64'($signed(w1p) >>> 25);
        n_s2 = 64'($signed(r_s1 + r_w1) >>> 8);
        pf   = r_s2 + ({{48{p7[15]}}, p7} << 4);
        // Clamp to the unsigned 32-bit range; a zero divisor forces zero.
        if (!r_sdd[0] || pf[63]) begin
            pres = '0;
        end else if (|pf[62:32]) begin
            pres = '1;
        end else begin
            pres = pf[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vpost   <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vpost   <= {r_vpost[2:0], div_vld};
            r_out_vld <= r_vpost[3];
        end
        if (en) begin
            r_pa  <= div_quo;
            r_psa <= ps;
            r_ma  <= mf[63:0];
            r_p8p <= p8f[63:0];
            r_sda <= div_side;
            r_ll  <= n_ll;
            r_hl  <= n_hl;
            r_lh  <= n_lh;
            r_w2  <= 64'($signed(r_p8p) >>> 19);
            r_pb  <= r_pa;
            r_sdb <= r_sda;
            r_w1  <= n_w1;
            r_s1  <= r_pb + r_w2;
            r_sdc <= r_sdb;
            r_s2  <= n_s2;
            r_sdd <= r_sdc;
            r_out_word.temperature_centi <= r_sdd[SIDE_W-1:1];
            r_out_word.pressure_q24_8    <= pres;
            r_out_word.pressure_valid    <= r_sdd[0];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

endmodule

// File: sv/baro_div.sv
// Pipelined signed 64-bit divider, one quotient bit per stage, with sideband.
// Depends on baro_pkg for the data width.
module baro_div #(
    parameter int SIDE_W = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  logic [baro_pkg::DIV_W-1:0] i_num,
    input  logic [baro_pkg::DIV_W-1:0] i_den,
    input  logic [SIDE_W-1:0]         i_side,
    output logic                      o_vld,
    output logic [baro_pkg::DIV_W-1:0] o_quo,
    output logic [SIDE_W-1:0]         o_side
);

    localparam int W = baro_pkg::DIV_W;

    logic [W:0]        r_vld;
    logic [W-1:0]      r_rem  [0:W];
    logic [W-1:0]      r_nq   [0:W];
    logic [W-1:0]      r_den  [0:W];
    logic              r_neg  [0:W];
    logic [SIDE_W-1:0] r_side [0:W];
    logic              r_out_vld;
    logic [W-1:0]      r_quo;
    logic [SIDE_W-1:0] r_out_side;

    // Operand magnitudes; the quotient sign is applied after the last step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
        if (i_en) begin
            r_rem[0]  <= '0;
            r_nq[0]   <= i_num[W-1] ? (~i_num + 1'b1) : i_num;
            r_den[0]  <= i_den[W-1] ? (~i_den + 1'b1) : i_den;
            r_neg[0]  <= i_num[W-1] ^ i_den[W-1];
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < W; k++) begin : g_step
        logic [W:0]   trial;
        logic         ge;
        logic [W-1:0] n_rem;
        logic [W-1:0] n_nq;

        always_comb begin
            trial = {r_rem[k], r_nq[k][W-1]} - {1'b0, r_den[k]};
            ge    = ~trial[W];
            n_rem = ge ? trial[W-1:0] : {r_rem[k][W-2:0], r_nq[k][W-1]};
            n_nq  = {r_nq[k][W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
            if (i_en) begin
                r_rem[k+1]  <= n_rem;
                r_nq[k+1]   <= n_nq;
                r_den[k+1]  <= r_den[k];
                r_neg[k+1]  <= r_neg[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_vld[W];
        end
        if (i_en) begin
            r_quo      <= r_neg[W] ? (~r_nq[W] + 1'b1) : r_nq[W];
            r_out_side <= r_side[W];
        end
    end

    assign o_vld  = r_out_vld;
    assign o_quo  = r_quo;
    assign o_side = r_out_side;

endmodule

// File: verif/tb.sv
// Self-checking testbench for baro_sensor_compensation_top.
// Depends on baro_pkg and the RTL; predicts each result with a local compensation model.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Scoreboard: holds the trim words and the queue of predicted results.
    class baro_scoreboard;
        logic [47:0] trim_t;
        logic [63:0] trim_pa;
        logic [63:0] trim_pb;
        logic [15:0] trim_pc;
        baro_pkg::t_out_word predicted_q[$];
        int          fail_count;

        function void set_trim(logic [baro_pkg::IDX_W-1:0] idx, logic [63:0] value);
            case (idx)
                baro_pkg::REG_TRIM_T:  trim_t  = value[47:0];
                baro_pkg::REG_TRIM_PA: trim_pa = value;
                baro_pkg::REG_TRIM_PB: trim_pb = value;
                baro_pkg::REG_TRIM_PC: trim_pc = value[15:0];
                default: ;
            endcase
        endfunction

        // Compensates one pair of readings with integer arithmetic:
        // 32-bit wrapping for temperature, 64-bit for pressure.
        function baro_pkg::t_out_word compensate(baro_pkg::t_in_word w);
            baro_pkg::t_out_word r;
            logic signed [31:0] t1, t2, t3, d1, v1t, d2, v2t, fine;
            logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
            logic signed [63:0] x, xx, v1, v2, p, ps, w1, w2, num, q;
            logic [63:0] ma, mb;
            t1 = {16'd0, trim_t[15:0]};
            t2 = {{16{trim_t[31]}}, trim_t[31:16]};
            t3 = {{16{trim_t[47]}}, trim_t[47:32]};
            d1 = {15'd0, w.adc_temperature[19:3]} - (t1 <<< 1);
            v1t = (d1 * t2) >>> 11;
            d2 = {16'd0, w.adc_temperature[19:4]} - t1;
            v2t = (((d2 * d2) >>> 12) * t3) >>> 14;
            fine = v1t + v2t;
            r.temperature_centi = (fine * 32'sd5 + 32'sd128) >>> 8;

            p1 = {48'd0, trim_pa[15:0]};
            p2 = {{48{trim_pa[31]}}, trim_pa[31:16]};
            p3 = {{48{trim_pa[47]}}, trim_pa[47:32]};
            p4 = {{48{trim_pa[63]}}, trim_pa[63:48]};
            p5 = {{48{trim_pb[15]}}, trim_pb[15:0]};
            p6 = {{48{trim_pb[31]}}, trim_pb[31:16]};
            p7 = {{48{trim_pb[47]}}, trim_pb[47:32]};
            p8 = {{48{trim_pb[63]}}, trim_pb[63:48]};
            p9 = {{48{trim_pc[15]}}, trim_pc};

            x = 64'(fine) - 64'sd128000;
            xx = x * x;
            v2 = xx * p6 + ((x * p5) <<< 17) + (p4 <<< 35);
            v1 = ((xx * p3) >>> 8) + ((x * p2) <<< 12);
            v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;

            r.pressure_q24_8 = '0;
            r.pressure_valid = 1'b0;
            if (v1 != 0) begin
                p = 64'sd1048576 - {44'd0, w.adc_pressure};
                num = ((p <<< 31) - v2) * 64'sd3125;
                // Truncating signed division on magnitudes; min / -1 wraps to itself.
                ma = num[63] ? -num : num;
                mb = v1[63] ? -v1 : v1;
                q = ma / mb;
                p = (num[63] != v1[63]) ? -q : q;
                ps = p >>> 13;
                w1 = (p9 * ps * ps) >>> 25;
                w2 = (p8 * p) >>> 19;
                p = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
                if (p[63])
                    r.pressure_q24_8 = '0;
                else if (p[62:32] != 0)
                    r.pressure_q24_8 = 32'hFFFF_FFFF;
                else
                    r.pressure_q24_8 = p[31:0];
                r.pressure_valid = 1'b1;
            end
            return r;
        endfunction

        function void note_input(baro_pkg::t_in_word w);
            predicted_q.push_back(compensate(w));
        endfunction

        function void check_result(baro_pkg::t_out_word got);
            baro_pkg::t_out_word exp_w;
            if (predicted_q.size() == 0) begin
                $display("%0t: unexpected result word %h", $realtime, got);
                fail_count++;
                return;
            end
            exp_w = predicted_q.pop_front();
            if (got.temperature_centi !== exp_w.temperature_centi) begin
                $display("%0t: temperature_centi expected %0d actual %0d", $realtime,
                         exp_w.temperature_centi, got.temperature_centi);
                fail_count++;
            end
            if (got.pressure_q24_8 !== exp_w.pressure_q24_8) begin
                $display("%0t: pressure_q24_8 expected %h actual %h", $realtime,
                         exp_w.pressure_q24_8, got.pressure_q24_8);
                fail_count++;
            end
            if (got.pressure_valid !== exp_w.pressure_valid) begin
                $display("%0t: pressure_valid expected %b actual %b", $realtime,
                         exp_w.pressure_valid, got.pressure_valid);
                fail_count++;
            end
        endfunction
    endclass

    localparam int LATENCY   = 83;
    localparam int N_RANDOM  = 930;
    localparam longint LIMIT = 400000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    baro_pkg::t_in_word            i_in_word = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    baro_pkg::t_out_word           o_out_word;
    logic                          i_cfg_we = 1'b0;
    logic [baro_pkg::IDX_W-1:0]    i_cfg_idx = '0;
    logic [baro_pkg::CFG_W-1:0]    i_cfg_data = '0;

    baro_scoreboard sb;
    longint cycle_count = 0;
    // When set, the receiver holds off for a long stretch so the pipeline fills.
    bit     hold_off_request = 1'b0;

    baro_sensor_compensation_top u_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Every accepted input word is predicted; every accepted result is checked.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.note_input(i_in_word);
            if (o_out_valid && i_out_ready)
                sb.check_result(o_out_word);
        end
        if (cycle_count > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45) return 0;
        if (sel < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, plus one long hold-off counted in its own cycles.
    initial begin
        int n;
        int quiet;
        quiet = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_request) begin
                i_out_ready <= 1'b0;
                for (n = 0; n < 300; n++) @(negedge i_clk);
                hold_off_request = 1'b0;
            end
            if (quiet > 0) begin
                quiet--;
                i_out_ready <= 1'b1;
            end else if ($urandom_range(0, 9) == 0) begin
                quiet = $urandom_range(50, 200);   // a stretch without stalls
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= (gap_len() == 0) || ($urandom_range(0, 1) == 1);
            end
        end
    end

    // Valid drops during a gap; with no gap it stays high into the next word.
    task automatic send_word(baro_pkg::t_in_word w, int gap);
        int n;
        for (n = 0; n < gap; n++) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Back-to-back words keep valid high across the handshake.
    task automatic send_burst(int count);
        int n;
        baro_pkg::t_in_word w;
        for (n = 0; n < count; n++) begin
            w.adc_temperature = 20'($urandom());
            w.adc_pressure    = 20'($urandom());
            i_in_valid <= 1'b1;
            i_in_word  <= w;
            @(posedge i_clk);
            while (!o_in_ready) @(posedge i_clk);
            @(negedge i_clk);
        end
    endtask

    task automatic write_trim(logic [baro_pkg::IDX_W-1:0] idx, logic [63:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_trim(idx, value);
    endtask

    // Stops offering words, waits for all predicted results, then lets the pipeline drain.
    task automatic drain();
        int n;
        i_in_valid <= 1'b0;
        while (sb.predicted_q.size() != 0) @(negedge i_clk);
        for (n = 0; n < LATENCY + 10; n++) @(negedge i_clk);
    endtask

    // A typical factory trim set; every trim field but T3 gets a random spread.
    task automatic load_typical_trims();
        logic [63:0] pa, pb;
        pa = {16'd2855 + 16'($urandom_range(0, 400)), 16'hF000 | 16'($urandom),
              16'hD000 | 16'($urandom_range(0, 4095)), 16'd36000 + 16'($urandom_range(0, 2000))};
        pb = {16'($urandom_range(0, 60000) + 16'hB000), 16'd15500 + 16'($urandom_range(0, 100)),
              16'($urandom), 16'd140 + 16'($urandom_range(0, 20))};
        write_trim(baro_pkg::REG_TRIM_T, 64'({16'hFC18, 16'd26400 + 16'($urandom_range(0, 800)),
                                         16'd27500 + 16'($urandom_range(0, 1000))}));
        write_trim(baro_pkg::REG_TRIM_PA, pa);
        write_trim(baro_pkg::REG_TRIM_PB, pb);
        write_trim(baro_pkg::REG_TRIM_PC, 64'(16'd6000 + 16'($urandom_range(0, 200))));
    endtask

    initial begin
        baro_pkg::t_in_word w;
        int k, phase, burst_len;
        sb = new();
        sb.trim_t = '0; sb.trim_pa = '0; sb.trim_pb = '0; sb.trim_pc = '0;
        sb.fail_count = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset trims give a zero divisor: pressure must come back invalid.
        w = '0;                          send_word(w, 0);
        w = '1;                          send_word(w, 1);
        drain();

        // Directed part with realistic trims, then the extremes of every word.
        load_typical_trims();
        w = '0;                          send_word(w, 0);
        w = '1;                          send_word(w, 0);
        w = {20'd519888, 20'd415148};    send_word(w, 2);
        w = {20'hAAAAA, 20'h55555};      send_word(w, 0);
        w = {20'h55555, 20'hAAAAA};      send_word(w, 0);
        w = {20'd0, 20'hFFFFF};          send_word(w, 1);
        w = {20'hFFFFF, 20'd0};          send_word(w, 0);
        drain();
        write_trim(baro_pkg::REG_TRIM_T, 64'h0000_FFFF_FFFF_FFFF);
        write_trim(baro_pkg::REG_TRIM_PA, 64'hFFFF_FFFF_FFFF_FFFF);
        write_trim(baro_pkg::REG_TRIM_PB, 64'hFFFF_FFFF_FFFF_FFFF);
        write_trim(baro_pkg::REG_TRIM_PC, 64'h0000_0000_0000_FFFF);
        w = '0;                          send_word(w, 0);
        w = '1;                          send_word(w, 0);
        drain();
        write_trim(baro_pkg::REG_TRIM_T, 64'h0000_7FFF_8000_FFFF);
        write_trim(baro_pkg::REG_TRIM_PA, 64'h8000_7FFF_8000_FFFF);
        write_trim(baro_pkg::REG_TRIM_PB, 64'h7FFF_8000_7FFF_8000);
        write_trim(baro_pkg::REG_TRIM_PC, 64'h0000_0000_0000_8000);
        w = '0;                          send_word(w, 0);
        w = '1;                          send_word(w, 0);
        w = {20'h80000, 20'h80000};      send_word(w, 0);
        drain();
        // P1 of zero forces a zero divisor while temperature still computes.
        write_trim(baro_pkg::REG_TRIM_PA, 64'h1234_5678_9ABC_0000);
        w = {20'd519888, 20'd415148};    send_word(w, 0);
        drain();
        // An unmapped index must leave the trims alone.
        write_trim(3'd5, 64'hDEAD_BEEF_0000_1111);
        write_trim(3'd7, 64'h0123_4567_89AB_CDEF);
        w = {20'd300000, 20'd1};         send_word(w, 0);
        drain();

        // Random phases: mostly realistic trims, some with fully random ones.
        for (phase = 0; phase < 6; phase++) begin
            if (phase % 3 == 2) begin
                write_trim(baro_pkg::REG_TRIM_T, {$urandom(), $urandom()});
                write_trim(baro_pkg::REG_TRIM_PA, {$urandom(), $urandom()});
                write_trim(baro_pkg::REG_TRIM_PB, {$urandom(), $urandom()});
                write_trim(baro_pkg::REG_TRIM_PC, 64'(16'($urandom())));
            end else begin
                load_typical_trims();
            end
            if (phase == 1) begin
                // The receiver stalls long while the sender keeps offering words.
                hold_off_request = 1'b1;
                send_burst(150);
            end
            // The loop counts words, so a burst uses up as many steps as it sends.
            for (k = 0; k < N_RANDOM / 6 - (phase == 1 ? 150 : 0); k++) begin
                w.adc_temperature = $urandom_range(0, 9) < 7 ?
                    20'd400000 + 20'($urandom_range(0, 250000)) : 20'($urandom());
                w.adc_pressure    = $urandom_range(0, 9) < 7 ?
                    20'd250000 + 20'($urandom_range(0, 250000)) : 20'($urandom());
                if ($urandom_range(0, 4) == 0) begin
                    burst_len = $urandom_range(2, 12);
                    send_burst(burst_len);
                    k += burst_len - 1;
                end else begin
                    send_word(w, gap_len());
                end
            end
            drain();
        end

        if (sb.fail_count == 0 && sb.predicted_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
